/* rtl/rcte_pkg.sv */
`default_nettype none
package rcte_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int KINDS = 12;
	localparam int MASK_W = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_MARK = 3'd1;
	localparam logic [2:0] OP_MOVE = 3'd2;
	localparam logic [2:0] OP_TICK = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] RK_ADD = 2'd0;
	localparam logic [1:0] RK_CONTACT = 2'd1;
	localparam logic [1:0] RK_ACK = 2'd2;
	localparam logic [1:0] RK_DONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_0_3 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_4_7 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_8_11 = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] slot_index;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0] rect_w;
		logic [14:0] rect_h;
		logic [3:0] kind_code;
		logic [7:0] listener_id;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [2:0] own_slot;
		logic [2:0] other_slot;
		logic [7:0] notify_id;
		logic table_full;
		logic last;
	} res_t;

	// contents of one slot as it travels along the chain
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0] width;
		logic [14:0] height;
		logic [3:0] kind;
		logic [7:0] listener;
	} slot_t;

	// command broadcast to every cell
	typedef struct packed {
		logic wr;       // write rect of addressed cell
		logic wr_full;  // also write kind and listener and set used
		logic mark;
		logic purge;    // free marked slots
		logic clear;
	} cell_cmd_t;

	function automatic logic allowed(input logic [3:0] src, input logic [3:0] dst,
		input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
		input logic [MASK_W-1:0] m2);
		logic [MASK_W-1:0] r;
		logic [5:0] b;
		begin
			r = (src < 4'd4) ? m0 : (src < 4'd8) ? m1 : m2;
			b = 6'(src[1:0]) * 6'd12 + 6'(dst);
			allowed = (src < 4'(KINDS)) && (dst < 4'(KINDS)) && r[b];
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/rcte_cell.sv */
`default_nettype none
// one slot of the table; the probe slot passes through one cell a cycle unless the walk is held
module rcte_cell #(
	parameter int IDX = 0,
	parameter int IW = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sel,
	input  wire rcte_pkg::cell_cmd_t cmd,
	input  wire rcte_pkg::slot_t wdata,
	output logic used,
	output rcte_pkg::slot_t data,
	// probe travelling along the chain
	input  wire logic pin_vld,
	input  wire logic [IW-1:0] pin_idx,
	input  wire rcte_pkg::slot_t pin,
	// hit found at this cell: probe against this slot
	output logic hit
);
	logic used_q, doomed_q;
	rcte_pkg::slot_t slot_q;
	logic signed [16:0] at_b, ab_b, al_r, bl_r;
	logic ovl;

	assign used = used_q;
	assign data = slot_q;

	assign at_b = 17'(pin.top) + 17'(signed'({1'b0, pin.height}));
	assign ab_b = 17'(slot_q.top) + 17'(signed'({1'b0, slot_q.height}));
	assign al_r = 17'(pin.left) + 17'(signed'({1'b0, pin.width}));
	assign bl_r = 17'(slot_q.left) + 17'(signed'({1'b0, slot_q.width}));
	assign ovl = !(at_b < 17'(slot_q.top) || 17'(pin.top) > ab_b ||
		al_r < 17'(slot_q.left) || 17'(pin.left) > bl_r);
	assign hit = pin_vld && used_q && (pin_idx < IW'(IDX)) && ovl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			doomed_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				used_q <= 1'b0;
				doomed_q <= 1'b0;
			end else if (cmd.purge) begin
				if (doomed_q) used_q <= 1'b0;
				doomed_q <= 1'b0;
			end else if (sel && cmd.wr_full) begin
				used_q <= 1'b1;
				doomed_q <= 1'b0;
			end else if (sel && cmd.mark && used_q) begin
				doomed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && (cmd.wr_full || (cmd.wr && used_q))) begin
			slot_q.left <= wdata.left;
			slot_q.top <= wdata.top;
			slot_q.width <= wdata.width;
			slot_q.height <= wdata.height;
		end
		if (sel && cmd.wr_full) begin
			slot_q.kind <= wdata.kind;
			slot_q.listener <= wdata.listener;
		end
	end

	a_purge_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> !used_q && !doomed_q) else $error("clear left slot used");
	a_doom_used: assert property (@(posedge clk) disable iff (!arst_n)
		doomed_q |-> used_q) else $error("mark on free slot");
	a_add_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sel && cmd.wr_full |=> used_q) else $error("add left slot free");

endmodule
`default_nettype wire

/* rtl/rect_collision_table_engine.sv */
`default_nettype none
// Slot table with pairwise rectangle contact search. Table operations (add,
// mark, move, clear) each give one result. A tick frees marked slots, then
// takes each used slot i as the probe and steps it along the row of slot
// cells, one cell per cycle, reporting contacts with every later slot k it
// touches, (i,k) then (k,i), where the pair mask and a nonzero listener allow
// them; a pair that reports both ways takes an extra state. A tick ends with a
// done result. While the one-deep output register is full and out_ready is
// low the walk stalls in place.
module rect_collision_table_engine #(
	parameter int SLOTS = rcte_pkg::SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire rcte_pkg::req_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output rcte_pkg::res_t out_data,
	input  wire logic cfg_we,
	input  wire logic [rcte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcte_pkg::MASK_W-1:0] cfg_data
);
	localparam int IW = 3;

	typedef enum logic [2:0] {S_IDLE, S_OP, S_PURGE, S_LOAD, S_WALK, S_PAIR2, S_DONE}
		state_t;
	state_t state_q;

	logic [rcte_pkg::MASK_W-1:0] m0_q, m1_q, m2_q;
	rcte_pkg::req_t req_q;
	rcte_pkg::cell_cmd_t cmd;
	rcte_pkg::slot_t wdata;
	logic [SLOTS-1:0] used, hit, sel;
	rcte_pkg::slot_t data [SLOTS];
	logic [IW-1:0] src_q, pos_q;
	logic [IW:0] free_idx;
	logic full;
	logic hold;
	logic res_load;

	function automatic rcte_pkg::res_t mk_res(input logic [1:0] kind,
		input logic [2:0] own, input logic [2:0] other, input logic [7:0] id,
		input logic tfull, input logic lst);
		rcte_pkg::res_t r;
		begin
			r.result_kind = kind;
			r.own_slot = own;
			r.other_slot = other;
			r.notify_id = id;
			r.table_full = tfull;
			r.last = lst;
			mk_res = r;
		end
	endfunction

	// lowest free slot
	always_comb begin
		free_idx = (IW+1)'(SLOTS);
		for (int j = SLOTS-1; j >= 0; j--)
			if (!used[j]) free_idx = (IW+1)'(j);
	end
	assign full = (free_idx == (IW+1)'(SLOTS));

	always_comb begin
		cmd = '0;
		sel = '0;
		wdata.left = req_q.rect_x;
		wdata.top = req_q.rect_y;
		wdata.width = req_q.rect_w;
		wdata.height = req_q.rect_h;
		wdata.kind = req_q.kind_code;
		wdata.listener = req_q.listener_id;
		// table operations change the table only in the cycle their result is loaded
		if (state_q == S_OP && !hold) begin
			case (req_q.operation)
				rcte_pkg::OP_ADD: begin
					cmd.wr_full = !full;
					for (int j = 0; j < SLOTS; j++) sel[j] = (free_idx == (IW+1)'(j));
				end
				rcte_pkg::OP_MARK: begin
					cmd.mark = 1'b1;
					for (int j = 0; j < SLOTS; j++) sel[j] = (req_q.slot_index == 3'(j));
				end
				rcte_pkg::OP_MOVE: begin
					cmd.wr = 1'b1;
					for (int j = 0; j < SLOTS; j++) sel[j] = (req_q.slot_index == 3'(j));
				end
				rcte_pkg::OP_CLEAR: cmd.clear = 1'b1;
				default: ;
			endcase
		end
		if (state_q == S_PURGE) cmd.purge = 1'b1;
	end

	// the probe walks; it stalls in place when the output is busy
	assign hold = out_valid && !out_ready;

	// probe sits at chain position pos_q while walking, examined by its cell
	logic hit_here;
	logic [IW-1:0] k_at;
	rcte_pkg::slot_t probe_q, other_d;
	logic r1, r2;
	assign k_at = pos_q;
	assign other_d = data[pos_q];
	assign hit_here = hit[pos_q];
	assign r1 = rcte_pkg::allowed(probe_q.kind, other_d.kind, m0_q, m1_q, m2_q)
		&& probe_q.listener != 8'd0;
	assign r2 = rcte_pkg::allowed(other_d.kind, probe_q.kind, m0_q, m1_q, m2_q)
		&& other_d.listener != 8'd0;

	assign res_load = !hold && ((state_q == S_OP) || (state_q == S_PAIR2) ||
		(state_q == S_DONE) || (state_q == S_WALK && hit_here && r1));

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			logic cell_pv;
			assign cell_pv = (state_q == S_WALK) && (pos_q == IW'(g));
			rcte_cell #(.IDX(g), .IW(IW)) u_cell (
				.clk, .arst_n, .sel(sel[g]), .cmd, .wdata,
				.used(used[g]), .data(data[g]),
				.pin_vld(cell_pv), .pin_idx(src_q), .pin(probe_q),
				.hit(hit[g]));
		end
	endgenerate

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			out_data <= '0;
			req_q <= '0;
			probe_q <= '0;
			m0_q <= '0;
			m1_q <= '0;
			m2_q <= '0;
			src_q <= '0;
			pos_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rcte_pkg::CFG_ROWS_0_3: m0_q <= cfg_data;
					rcte_pkg::CFG_ROWS_4_7: m1_q <= cfg_data;
					rcte_pkg::CFG_ROWS_8_11: m2_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					req_q <= in_data;
					state_q <= (in_data.operation == rcte_pkg::OP_TICK) ? S_PURGE : S_OP;
				end
				S_OP: if (!hold) begin
					if (req_q.operation == rcte_pkg::OP_ADD)
						out_data <= mk_res(rcte_pkg::RK_ADD, full ? 3'd0 : 3'(free_idx),
							3'd0, 8'd0, full, 1'b1);
					else
						out_data <= mk_res(rcte_pkg::RK_ACK, 3'd0, 3'd0, 8'd0, 1'b0, 1'b1);
					state_q <= S_IDLE;
				end
				S_PURGE: begin
					src_q <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (used[src_q] && src_q != IW'(SLOTS-1)) begin
						probe_q <= data[src_q];
						pos_q <= src_q + IW'(1);
						state_q <= S_WALK;
					end else if (src_q == IW'(SLOTS-1)) begin
						state_q <= S_DONE;
					end else begin
						src_q <= src_q + IW'(1);
					end
				end
				S_WALK: if (!hold) begin
					if (hit_here && r1)
						out_data <= mk_res(rcte_pkg::RK_CONTACT, src_q, k_at,
							probe_q.listener, 1'b0, 1'b0);
					if (hit_here && r2) state_q <= S_PAIR2;
					else if (pos_q == IW'(SLOTS-1)) begin
						src_q <= src_q + IW'(1);
						state_q <= (src_q + IW'(1) == IW'(SLOTS-1)) ? S_DONE : S_LOAD;
					end else pos_q <= pos_q + IW'(1);
				end
				S_PAIR2: if (!hold) begin
					out_data <= mk_res(rcte_pkg::RK_CONTACT, k_at, src_q,
						other_d.listener, 1'b0, 1'b0);
					if (pos_q == IW'(SLOTS-1)) begin
						src_q <= src_q + IW'(1);
						state_q <= (src_q + IW'(1) == IW'(SLOTS-1)) ? S_DONE : S_LOAD;
					end else begin
						pos_q <= pos_q + IW'(1);
						state_q <= S_WALK;
					end
				end
				S_DONE: if (!hold) begin
					out_data <= mk_res(rcte_pkg::RK_DONE, 3'd0, 3'd0, 8'd0, 1'b0, 1'b1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> $stable(out_data) && out_valid) else $error("result changed while stalled");
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> pos_q > src_q) else $error("pair order broken");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !$past(state_q == S_WALK) || $past(pos_q) == IW'(SLOTS-1))
		else $error("tick cut short");

endmodule
`default_nettype wire

/* bench/rcte_checker.sv */
`timescale 1ns / 100ps
module rcte_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire rcte_pkg::req_t in_data,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire rcte_pkg::res_t out_data,
	input  wire logic cfg_we,
	input  wire logic [rcte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcte_pkg::MASK_W-1:0] cfg_data,
	output int errors,
	output int pending
);
	import rcte_pkg::*;

	localparam int N = 8;

	logic [MASK_W-1:0] mask_lo, mask_mid, mask_hi;
	logic used [N];
	logic doomed [N];
	slot_t table_q [N];
	res_t expected_q [$];

	assign pending = expected_q.size();

	function automatic bit may_report(logic [3:0] src, logic [3:0] dst);
		logic [MASK_W-1:0] r;
		if (src > 4'd11 || dst > 4'd11)
			return 0;
		r = (src < 4'd4) ? mask_lo : (src < 4'd8) ? mask_mid : mask_hi;
		return r[int'(src[1:0]) * 12 + int'(dst)];
	endfunction

	function automatic bit touches(slot_t a, slot_t b);
		int at, ab, al, ar, bt, bb, bl, br;
		at = a.top; ab = a.top + int'(a.height);
		al = a.left; ar = a.left + int'(a.width);
		bt = b.top; bb = b.top + int'(b.height);
		bl = b.left; br = b.left + int'(b.width);
		return !(ab < bt || at > bb || ar < bl || al > br);
	endfunction

	function automatic res_t mk(logic [1:0] kind, int own, int other, logic [7:0] id,
		bit full, bit lst);
		res_t r;
		r.result_kind = kind;
		r.own_slot = own[2:0];
		r.other_slot = other[2:0];
		r.notify_id = id;
		r.table_full = full;
		r.last = lst;
		return r;
	endfunction

	task automatic apply_request(req_t q);
		int free_slot;
		slot_t s;
		free_slot = -1;
		s.left = q.rect_x; s.top = q.rect_y; s.width = q.rect_w; s.height = q.rect_h;
		s.kind = q.kind_code; s.listener = q.listener_id;
		case (q.operation)
			OP_ADD: begin
				for (int i = N - 1; i >= 0; i--)
					if (!used[i]) free_slot = i;
				if (free_slot < 0)
					expected_q.push_back(mk(RK_ADD, 0, 0, 0, 1, 1));
				else begin
					used[free_slot] = 1;
					doomed[free_slot] = 0;
					table_q[free_slot] = s;
					expected_q.push_back(mk(RK_ADD, free_slot, 0, 0, 0, 1));
				end
			end
			OP_TICK: begin
				for (int i = 0; i < N; i++) begin
					if (doomed[i]) used[i] = 0;
					doomed[i] = 0;
				end
				for (int i = 0; i < N; i++)
					for (int k = i + 1; k < N; k++)
						if (used[i] && used[k] && touches(table_q[i], table_q[k])) begin
							if (may_report(table_q[i].kind, table_q[k].kind)
								&& table_q[i].listener != 0)
								expected_q.push_back(mk(RK_CONTACT, i, k,
									table_q[i].listener, 0, 0));
							if (may_report(table_q[k].kind, table_q[i].kind)
								&& table_q[k].listener != 0)
								expected_q.push_back(mk(RK_CONTACT, k, i,
									table_q[k].listener, 0, 0));
						end
				expected_q.push_back(mk(RK_DONE, 0, 0, 0, 0, 1));
			end
			default: begin
				if (q.operation == OP_MARK && used[q.slot_index])
					doomed[q.slot_index] = 1;
				else if (q.operation == OP_MOVE && used[q.slot_index]) begin
					table_q[q.slot_index].left = s.left;
					table_q[q.slot_index].top = s.top;
					table_q[q.slot_index].width = s.width;
					table_q[q.slot_index].height = s.height;
				end else if (q.operation == OP_CLEAR)
					for (int i = 0; i < N; i++) begin
						used[i] = 0;
						doomed[i] = 0;
					end
				expected_q.push_back(mk(RK_ACK, 0, 0, 0, 0, 1));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			mask_lo = '0; mask_mid = '0; mask_hi = '0;
			for (int i = 0; i < N; i++) begin
				used[i] = 0;
				doomed[i] = 0;
			end
			expected_q.delete();
		end else begin
			if (cfg_we)
				case (cfg_index)
					CFG_ROWS_0_3: mask_lo = cfg_data;
					CFG_ROWS_4_7: mask_mid = cfg_data;
					CFG_ROWS_8_11: mask_hi = cfg_data;
					default: ;
				endcase
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time,
						out_data);
					errors <= errors + 1;
				end else begin
					if (out_data !== expected_q[0]) begin
						$display("%0t: mismatch, expected %p, actual %p", $time,
							expected_q[0], out_data);
						errors <= errors + 1;
					end
					void'(expected_q.pop_front());
				end
			end
			// predict after comparing so a same-cycle request never overtakes
			if (in_valid && in_ready)
				apply_request(in_data);
		end
	end
endmodule

/* bench/tb_rect_collision_table_engine.sv */
`timescale 1ns / 100ps
module tb_rect_collision_table_engine;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	rcte_pkg::req_t in_data;
	rcte_pkg::res_t out_data;
	logic cfg_we;
	logic [rcte_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rcte_pkg::MASK_W-1:0] cfg_data;
	int errors, pending;
	bit calm;

	rect_collision_table_engine u_dut (.*);

	rcte_checker u_check (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 16);
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// valid stays up after acceptance until the next call or drain changes it
	task automatic send_request(rcte_pkg::req_t q);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_data <= q;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(logic [rcte_pkg::CFG_IDX_W-1:0] idx,
		logic [rcte_pkg::MASK_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic rcte_pkg::req_t make_request(logic [2:0] op, logic [2:0] slot,
		int x, int y, int w, int h, int kind, int id);
		rcte_pkg::req_t q;
		q.operation = op; q.slot_index = slot;
		q.rect_x = x[15:0]; q.rect_y = y[15:0];
		q.rect_w = w[14:0]; q.rect_h = h[14:0];
		q.kind_code = kind[3:0]; q.listener_id = id[7:0];
		return q;
	endfunction

	// mostly small clustered rectangles so contacts are common
	function automatic rcte_pkg::req_t random_request();
		rcte_pkg::req_t q;
		int r;
		q = make_request(rcte_pkg::OP_ADD, 3'($urandom_range(0, 7)),
			$urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
			$urandom_range(0, 20), $urandom_range(0, 20),
			$urandom_range(0, 13), $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 255));
		r = $urandom_range(0, 99);
		if (r < 30) q.operation = rcte_pkg::OP_ADD;
		else if (r < 45) q.operation = rcte_pkg::OP_MARK;
		else if (r < 60) q.operation = rcte_pkg::OP_MOVE;
		else if (r < 88) q.operation = rcte_pkg::OP_TICK;
		else if (r < 92) q.operation = rcte_pkg::OP_CLEAR;
		else if (r < 95) q.operation = 3'($urandom_range(5, 7));
		else q = rcte_pkg::req_t'(80'({$urandom, $urandom, $urandom}));
		if (r >= 95 && q.operation > rcte_pkg::OP_CLEAR && q.operation < 3'd5)
			q.operation = rcte_pkg::OP_TICK;
		return q;
	endfunction

	initial begin
		int tb_phase;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_mask(rcte_pkg::CFG_ROWS_0_3, '1);
		write_mask(rcte_pkg::CFG_ROWS_4_7, '1);
		write_mask(rcte_pkg::CFG_ROWS_8_11, '1);
		// directed: extremes, touching edges, full table, marks, odd codes
		send_request(make_request(rcte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -32768, -32768, 32767, 32767, 0, 255));
		send_request(make_request(rcte_pkg::OP_ADD, 0, 32767, 32767, 32767, 32767, 11, 1));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -1, -1, 0, 0, 12, 7));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -1, -1, 0, 0, 15, 0));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -32768, 32767, 0, 0, 5, 9));
		send_request(make_request(rcte_pkg::OP_ADD, 0, 0, -1, 0, 0, 7, 200));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -1, 0, 5, 5, 8, 170));
		send_request(make_request(rcte_pkg::OP_ADD, 0, 100, 100, 1, 1, 3, 85));
		send_request(make_request(rcte_pkg::OP_ADD, 0, 0, 0, 1, 1, 0, 1));
		send_request(make_request(rcte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_MARK, 3, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_MARK, 3, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_ADD, 0, 0, 0, 1, 1, 0, 1));
		send_request(make_request(rcte_pkg::OP_MOVE, 7, 32767, -32768, 32767, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_ADD, 0, -1, -1, 2, 2, 4, 3));
		send_request(make_request(rcte_pkg::OP_MARK, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_MOVE, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(3'd5, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(3'd7, 7, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_MARK, 2, 0, 0, 0, 0, 0, 0));
		send_request(make_request(rcte_pkg::OP_MOVE, 2, 0, 0, 0, 0, 0, 0));
		drain();

		// random phases under different pair masks, zero mask among them
		for (tb_phase = 0; tb_phase < 5; tb_phase++) begin
			case (tb_phase)
				0: begin
					write_mask(rcte_pkg::CFG_ROWS_0_3, '0);
					write_mask(rcte_pkg::CFG_ROWS_4_7, '0);
					write_mask(rcte_pkg::CFG_ROWS_8_11, '0);
				end
				4: begin
					calm = 1;
					write_mask(rcte_pkg::CFG_ROWS_0_3, '1);
					write_mask(rcte_pkg::CFG_ROWS_4_7, '1);
					write_mask(rcte_pkg::CFG_ROWS_8_11, '1);
				end
				default: begin
					write_mask(rcte_pkg::CFG_ROWS_0_3, 48'({$urandom, $urandom}));
					write_mask(rcte_pkg::CFG_ROWS_4_7, 48'({$urandom, $urandom}));
					write_mask(rcte_pkg::CFG_ROWS_8_11, 48'({$urandom, $urandom}));
				end
			endcase
			repeat (45) send_request(random_request());
			if (tb_phase == 2) drain();
			repeat (5) send_request(random_request());
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* filelist.f */
rtl/rcte_pkg.sv
rtl/rcte_cell.sv
rtl/rect_collision_table_engine.sv
bench/rcte_checker.sv
bench/tb_rect_collision_table_engine.sv
